@@ sv/wtoh_pkg.sv @@
// Shared constants, register codes and types of the wavetable Hermite oscillator.
package wtoh_pkg;

	localparam int TABLE_DEPTH   = 2048;
	localparam int FRAMES        = 4;
	localparam int FRACTION_BITS = 16;

	localparam int STORE_SIZE = TABLE_DEPTH * FRAMES;
	localparam int IDX_W      = $clog2(TABLE_DEPTH);
	localparam int RAM_ADDR_W = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

	// field widths
	localparam int LOAD_ADDR_W  = 13;
	localparam int SAMPLE_W     = 16;
	localparam int PHASE_W      = 32;
	localparam int FRAME_SEL_W  = 2;
	localparam int GAIN_W       = 17;
	localparam int PAN_W        = 16;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;

	// opcodes
	localparam logic OP_RENDER = 1'b0;
	localparam logic OP_LOAD   = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_SELECT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VELOCITY     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAN_LEFT     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PAN_RIGHT    = 3'd5;

	localparam logic [PAN_W-1:0] PAN_RESET = 16'd23170;

	// result queue
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	typedef struct packed {
		logic [GAIN_W-1:0] level;
		logic [GAIN_W-1:0] velocity;
		logic [PAN_W-1:0]  pan_left;
		logic [PAN_W-1:0]  pan_right;
	} wtoh_gain_t;

endpackage

@@ sv/wtoh_if.sv @@
// Handshake channels of the oscillator: items in, results out, register writes.
interface wtoh_item_if;
	logic                                       valid;
	logic                                       ready;
	logic                                       opcode;
	logic [wtoh_pkg::LOAD_ADDR_W-1:0]           load_address;
	logic signed [wtoh_pkg::SAMPLE_W-1:0]       load_value;

	modport source(output valid, opcode, load_address, load_value, input ready);
	modport sink(input valid, opcode, load_address, load_value, output ready);
endinterface

interface wtoh_result_if;
	logic                                       valid;
	logic                                       ready;
	logic signed [wtoh_pkg::SAMPLE_W-1:0]       left_sample;
	logic signed [wtoh_pkg::SAMPLE_W-1:0]       right_sample;

	modport source(output valid, left_sample, right_sample, input ready);
	modport sink(input valid, left_sample, right_sample, output ready);
endinterface

interface wtoh_cfg_if;
	logic                                       valid;
	logic                                       ready;
	logic [wtoh_pkg::CFG_IDX_W-1:0]             index;
	logic [wtoh_pkg::CFG_DATA_W-1:0]            data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ sv/wtoh_table_ram.sv @@
// Single-port sample table, one access a cycle, registered read data.
module wtoh_table_ram (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic                                 we,
	input  logic [wtoh_pkg::RAM_ADDR_W-1:0]      addr,
	input  logic signed [wtoh_pkg::SAMPLE_W-1:0] wdata,
	output logic signed [wtoh_pkg::SAMPLE_W-1:0] rdata
);
	import wtoh_pkg::*;

	logic signed [SAMPLE_W-1:0] mem_q [STORE_SIZE];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

@@ sv/wtoh_interp.sv @@
// Cubic Hermite interpolation, gain and pan pipeline: seven registered stages.
module wtoh_interp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [wtoh_pkg::SAMPLE_W-1:0] v0,
	input  logic signed [wtoh_pkg::SAMPLE_W-1:0] v1,
	input  logic signed [wtoh_pkg::SAMPLE_W-1:0] v2,
	input  logic signed [wtoh_pkg::SAMPLE_W-1:0] v3,
	input  logic [wtoh_pkg::FRACTION_BITS-1:0]   frac,
	input  wtoh_pkg::wtoh_gain_t                 gain,
	output logic                                 done,
	output logic signed [wtoh_pkg::SAMPLE_W-1:0] left_sample,
	output logic signed [wtoh_pkg::SAMPLE_W-1:0] right_sample
);
	import wtoh_pkg::*;

	localparam int F     = FRACTION_BITS;
	localparam int D_W   = SAMPLE_W + 1;
	localparam int A_W   = D_W + 3;
	localparam int B_W   = D_W + 4;
	localparam int FS_W  = F + 1;
	localparam int T_W   = B_W + F + 1;
	localparam int Q1_W  = T_W - (F - 8);
	localparam int P2_W  = Q1_W + FS_W;
	localparam int Q2_W  = Q1_W + 1;
	localparam int P3_W  = Q2_W + FS_W;
	localparam int Q3_W  = Q2_W + 1;
	localparam int GS_W  = GAIN_W + 1;
	localparam int PG1_W = Q3_W + GS_W;
	localparam int G1_W  = PG1_W - 16;
	localparam int PG2_W = G1_W + GS_W;
	localparam int G2_W  = PG2_W - 16;
	localparam int PS_W  = PAN_W + 1;
	localparam int PP_W  = G2_W + PS_W;
	localparam int SH_W  = PP_W - 24;

	// stage 1: slopes and doubled coefficients
	logic signed [D_W-1:0]      s0, s1, d;
	logic signed [A_W-1:0]      a_c;
	logic signed [B_W-1:0]      b_c;
	logic signed [A_W-1:0]      a_s1;
	logic signed [B_W-1:0]      b_s1;
	logic signed [D_W-1:0]      s0_s1, s0_s2, s0_s3;
	logic signed [SAMPLE_W-1:0] v1_s1, v1_s2, v1_s3;
	logic signed [FS_W-1:0]     fs_s1, fs_s2, fs_s3;
	logic                       vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	// Horner stages
	logic signed [T_W-1:0]      t_c;
	logic signed [Q1_W-1:0]     q1_s2;
	logic signed [P2_W-1:0]     p2_c;
	logic signed [Q2_W-1:0]     q2_s3;
	logic signed [P3_W-1:0]     p3_c;
	logic signed [Q3_W-1:0]     q3_s4;

	// gain and pan
	logic signed [GS_W-1:0]     lvl_s, vel_s;
	logic signed [PS_W-1:0]     pl_s, pr_s;
	logic signed [PG1_W-1:0]    pg1_c;
	logic signed [G1_W-1:0]     g1_s5;
	logic signed [PG2_W-1:0]    pg2_c;
	logic signed [G2_W-1:0]     g2_s6;
	logic signed [PP_W-1:0]     ppl_c, ppr_c;
	logic signed [SH_W-1:0]     shl_c, shr_c;
	logic signed [SAMPLE_W-1:0] left_s7, right_s7;

	function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SH_W-1:0] x);
		logic signed [SAMPLE_W-1:0] r;
		if (x > SH_W'(32767)) begin
			r = 16'sh7FFF;
		end else if (x < -SH_W'(32768)) begin
			r = -16'sh8000;
		end else begin
			r = SAMPLE_W'(x);
		end
		return r;
	endfunction

	always_comb begin
		s0  = D_W'(v2) - D_W'(v0);
		s1  = D_W'(v3) - D_W'(v1);
		d   = D_W'(v1) - D_W'(v2);
		a_c = A_W'(s0) + (A_W'(d) <<< 2) + A_W'(s1);
		b_c = (B_W'(s0) <<< 1) + (B_W'(d) <<< 2) + (B_W'(d) <<< 1) + B_W'(s1);
	end

	always_comb begin
		t_c   = T_W'(a_s1) * T_W'(fs_s1) - (T_W'(b_s1) <<< F);
		p2_c  = P2_W'(q1_s2) * P2_W'(fs_s2);
		p3_c  = P3_W'(q2_s3) * P3_W'(fs_s3);
		lvl_s = signed'({1'b0, gain.level});
		vel_s = signed'({1'b0, gain.velocity});
		pl_s  = signed'({1'b0, gain.pan_left});
		pr_s  = signed'({1'b0, gain.pan_right});
		pg1_c = PG1_W'(q3_s4) * PG1_W'(lvl_s);
		pg2_c = PG2_W'(g1_s5) * PG2_W'(vel_s);
		ppl_c = PP_W'(g2_s6) * PP_W'(pl_s);
		ppr_c = PP_W'(g2_s6) * PP_W'(pr_s);
		shl_c = SH_W'(ppl_c >>> 24);
		shr_c = SH_W'(ppr_c >>> 24);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		a_s1     <= a_c;
		b_s1     <= b_c;
		s0_s1    <= s0;
		v1_s1    <= v1;
		fs_s1    <= signed'({1'b0, frac});

		q1_s2    <= Q1_W'(t_c >>> (F - 8));
		s0_s2    <= s0_s1;
		v1_s2    <= v1_s1;
		fs_s2    <= fs_s1;

		q2_s3    <= Q2_W'(p2_c >>> F) + (Q2_W'(s0_s2) <<< 8);
		s0_s3    <= s0_s2;
		v1_s3    <= v1_s2;
		fs_s3    <= fs_s2;

		q3_s4    <= Q3_W'(p3_c >>> F) + (Q3_W'(v1_s3) <<< 9);

		g1_s5    <= G1_W'(pg1_c >>> 16);
		g2_s6    <= G2_W'(pg2_c >>> 16);

		left_s7  <= sat16(shl_c);
		right_s7 <= sat16(shr_c);
	end

	assign done         = vld_s7;
	assign left_sample  = left_s7;
	assign right_sample = right_s7;

endmodule

@@ sv/wavetable_oscillator_hermite.sv @@
// Wavetable oscillator voice with cubic Hermite interpolation, panned stereo output.
// A render beat issues four table reads on the single RAM port, one a cycle; the
// item channel is held while the sequencer reads after a render, not after a load.
// Results enter the queue as the interpolator finishes them; up to four results queue.
// Reset clears the phase, the result queue and the registers to their defaults;
// the sample table is not cleared and must be loaded before it is played.
module wavetable_oscillator_hermite (
	input  logic          clk,
	input  logic          arst_n,
	wtoh_item_if.sink     items,
	wtoh_result_if.source results,
	wtoh_cfg_if.sink      cfg
);
	import wtoh_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	// configuration
	logic [PHASE_W-1:0]     phase_step_q;
	logic [FRAME_SEL_W-1:0] frame_select_q;
	wtoh_gain_t             gain_q;

	logic [PHASE_W-1:0]     phase_q;
	logic                   state_q;
	logic [1:0]             cnt_q;
	logic [IDX_W-1:0]       idx_q;
	logic [FRAME_SEL_W-1:0] frame_q;
	logic [FRACTION_BITS-1:0] frac_q;
	logic                   rd_vld_q;
	logic [1:0]             rd_slot_q;
	logic signed [SAMPLE_W-1:0] v0_q, v1_q, v2_q;

	logic [RES_CNT_W-1:0]   outstanding_q;
	logic [RES_CNT_W-1:0]   fifo_cnt_q;
	logic [RES_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic signed [SAMPLE_W-1:0] res_l_q [RES_DEPTH];
	logic signed [SAMPLE_W-1:0] res_r_q [RES_DEPTH];

	logic                   accept, render_acc, load_acc, load_hit, pop;
	logic [FRAME_SEL_W-1:0] frame_clamped, rd_frame;
	logic [IDX_W-1:0]       rd_idx, rd_pos;
	logic [1:0]             rd_k;
	logic                   ram_en, ram_we;
	logic [RAM_ADDR_W-1:0]  ram_addr;
	logic signed [SAMPLE_W-1:0] ram_rdata;
	logic                   launch;
	logic                   res_done;
	logic signed [SAMPLE_W-1:0] res_left, res_right;

	assign items.ready = (state_q == ST_IDLE) && (outstanding_q < RES_CNT_W'(RES_DEPTH));
	assign accept      = items.valid && items.ready;
	assign render_acc  = accept && (items.opcode == OP_RENDER);
	assign load_acc    = accept && (items.opcode == OP_LOAD);
	assign load_hit    = load_acc && (32'(items.load_address) < STORE_SIZE);

	assign frame_clamped = (32'(frame_select_q) > FRAMES - 1) ?
		FRAME_SEL_W'(FRAMES - 1) : frame_select_q;

	// first read comes straight off the phase; the other three use the captured index
	always_comb begin
		if (state_q == ST_IDLE) begin
			rd_idx   = phase_q[PHASE_W-1 -: IDX_W];
			rd_k     = 2'd0;
			rd_frame = frame_clamped;
		end else begin
			rd_idx   = idx_q;
			rd_k     = cnt_q;
			rd_frame = frame_q;
		end
		rd_pos = rd_idx + IDX_W'(rd_k) - IDX_W'(1);
	end

	always_comb begin
		ram_we = load_hit;
		ram_en = load_hit || render_acc || (state_q == ST_READ);
		if (load_hit) begin
			ram_addr = RAM_ADDR_W'(items.load_address);
		end else begin
			ram_addr = RAM_ADDR_W'(32'(rd_frame) * TABLE_DEPTH + 32'(rd_pos));
		end
	end

	wtoh_table_ram u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (items.load_value),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q     <= '0;
			frame_select_q   <= '0;
			gain_q.level     <= '0;
			gain_q.velocity  <= '0;
			gain_q.pan_left  <= PAN_RESET;
			gain_q.pan_right <= PAN_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_PHASE_STEP:   phase_step_q     <= cfg.data[PHASE_W-1:0];
				REG_FRAME_SELECT: frame_select_q   <= cfg.data[FRAME_SEL_W-1:0];
				REG_LEVEL:        gain_q.level     <= cfg.data[GAIN_W-1:0];
				REG_VELOCITY:     gain_q.velocity  <= cfg.data[GAIN_W-1:0];
				REG_PAN_LEFT:     gain_q.pan_left  <= cfg.data[PAN_W-1:0];
				REG_PAN_RIGHT:    gain_q.pan_right <= cfg.data[PAN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	// read sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			rd_vld_q  <= 1'b0;
			rd_slot_q <= '0;
		end else begin
			rd_vld_q  <= ram_en && !ram_we;
			rd_slot_q <= rd_k;
			case (state_q)
				ST_IDLE: begin
					if (render_acc) begin
						state_q <= ST_READ;
						cnt_q   <= 2'd1;
						phase_q <= phase_q + phase_step_q;
					end
				end
				ST_READ: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (render_acc) begin
			idx_q   <= phase_q[PHASE_W-1 -: IDX_W];
			frac_q  <= phase_q[PHASE_W-1-IDX_W -: FRACTION_BITS];
			frame_q <= frame_clamped;
		end
		if (rd_vld_q) begin
			if (rd_slot_q == 2'd0) begin
				v0_q <= ram_rdata;
			end else if (rd_slot_q == 2'd1) begin
				v1_q <= ram_rdata;
			end else if (rd_slot_q == 2'd2) begin
				v2_q <= ram_rdata;
			end
		end
	end

	// fourth sample goes straight from the RAM into the pipeline
	assign launch = rd_vld_q && (rd_slot_q == 2'd3);

	wtoh_interp u_interp (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (launch),
		.v0           (v0_q),
		.v1           (v1_q),
		.v2           (v2_q),
		.v3           (ram_rdata),
		.frac         (frac_q),
		.gain         (gain_q),
		.done         (res_done),
		.left_sample  (res_left),
		.right_sample (res_right)
	);

	// result queue; a slot is reserved when the render beat is taken
	assign pop = results.valid && results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
			fifo_cnt_q    <= '0;
			wr_ptr_q      <= '0;
			rd_ptr_q      <= '0;
		end else begin
			outstanding_q <= outstanding_q + RES_CNT_W'(render_acc) - RES_CNT_W'(pop);
			fifo_cnt_q    <= fifo_cnt_q + RES_CNT_W'(res_done) - RES_CNT_W'(pop);
			if (res_done) begin
				wr_ptr_q <= wr_ptr_q + RES_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_done) begin
			res_l_q[wr_ptr_q] <= res_left;
			res_r_q[wr_ptr_q] <= res_right;
		end
	end

	assign results.valid        = (fifo_cnt_q != '0);
	assign results.left_sample  = res_l_q[rd_ptr_q];
	assign results.right_sample = res_r_q[rd_ptr_q];

endmodule

@@ tb/sv/wavetable_oscillator_hermite_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the wavetable Hermite oscillator: directed and random beats.
module wavetable_oscillator_hermite_tb;
	import wtoh_pkg::*;

	localparam int DRAIN_CYCLES  = 20;
	localparam int STALL_LIMIT   = 3000;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_ITEMS   = 118;
	localparam int RANDOM_PHASES = 12;

	typedef struct {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
	} stereo_t;

	// Predicts the stereo output of every render beat and holds it until it comes out.
	class voice_scoreboard;
		logic [PHASE_W-1:0]         step_reg;
		logic [FRAME_SEL_W-1:0]     frame_reg;
		wtoh_gain_t                 gains;
		logic [PHASE_W-1:0]         phase;
		logic signed [SAMPLE_W-1:0] wave [STORE_SIZE];
		stereo_t                    stereo_q [$];
		int                         errors;
		int                         checked;

		function new();
			step_reg        = '0;
			frame_reg       = '0;
			gains.level     = '0;
			gains.velocity  = '0;
			gains.pan_left  = PAN_RESET;
			gains.pan_right = PAN_RESET;
			phase           = '0;
			errors          = 0;
			checked         = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_PHASE_STEP:   step_reg        = data[PHASE_W-1:0];
				REG_FRAME_SELECT: frame_reg       = data[FRAME_SEL_W-1:0];
				REG_LEVEL:        gains.level     = data[GAIN_W-1:0];
				REG_VELOCITY:     gains.velocity  = data[GAIN_W-1:0];
				REG_PAN_LEFT:     gains.pan_left  = data[PAN_W-1:0];
				REG_PAN_RIGHT:    gains.pan_right = data[PAN_W-1:0];
				default: ;
			endcase
		endfunction

		function longint clip16(longint x);
			if (x > 32767)
				return 32767;
			if (x < -32768)
				return -32768;
			return x;
		endfunction

		// neighbour off-1 of idx, wrapping inside the frame
		function longint tap(longint base, longint idx, int off);
			return longint'(wave[base + (idx + off + TABLE_DEPTH - 1) % TABLE_DEPTH]);
		endfunction

		function void note_item(logic op, logic [LOAD_ADDR_W-1:0] addr,
				logic signed [SAMPLE_W-1:0] value);
			longint     frame, base, idx, f;
			longint     v0, v1, v2, v3, s0, s1, d, a, b, q1, q2, q3, g;
			logic [63:0] pos;
			stereo_t    res;
			if (op == OP_LOAD) begin
				if (addr < STORE_SIZE)
					wave[addr] = value;
				return;
			end
			frame = longint'(frame_reg);
			if (frame > FRAMES - 1)
				frame = FRAMES - 1;
			base = frame * TABLE_DEPTH;
			pos  = {32'b0, phase} * 64'(TABLE_DEPTH);
			idx  = longint'(pos >> 32) % TABLE_DEPTH;
			f    = longint'(pos[31:0] >> (32 - FRACTION_BITS));
			v0 = tap(base, idx, 0);
			v1 = tap(base, idx, 1);
			v2 = tap(base, idx, 2);
			v3 = tap(base, idx, 3);
			s0 = v2 - v0;
			s1 = v3 - v1;
			d  = v1 - v2;
			a  = s0 + 4 * d + s1;
			b  = 2 * s0 + 6 * d + s1;
			// Horner form with 8 spare fraction bits, every shift floors
			q1 = (a * f - b * (longint'(1) << FRACTION_BITS)) >>> (FRACTION_BITS - 8);
			q2 = ((q1 * f) >>> FRACTION_BITS) + s0 * 256;
			q3 = ((q2 * f) >>> FRACTION_BITS) + v1 * 512;
			g  = (q3 * longint'(gains.level)) >>> 16;
			g  = (g * longint'(gains.velocity)) >>> 16;
			res.left  = SAMPLE_W'(clip16((g * longint'(gains.pan_left)) >>> 24));
			res.right = SAMPLE_W'(clip16((g * longint'(gains.pan_right)) >>> 24));
			stereo_q.push_back(res);
			phase = phase + step_reg;
		endfunction

		function int pending();
			return stereo_q.size();
		endfunction

		function void compare_field(string name, logic signed [SAMPLE_W-1:0] want,
				logic signed [SAMPLE_W-1:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
			stereo_t want;
			if (stereo_q.size() == 0) begin
				errors++;
				$display("%0t: result beat L=%0d R=%0d with nothing expected", $time, l, r);
				return;
			end
			want = stereo_q.pop_front();
			checked++;
			compare_field("left_sample", want.left, l);
			compare_field("right_sample", want.right, r);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	wtoh_item_if   items_ch ();
	wtoh_result_if results_ch ();
	wtoh_cfg_if    cfg_ch ();

	wavetable_oscillator_hermite i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_ch),
		.results (results_ch),
		.cfg     (cfg_ch)
	);

	voice_scoreboard sb;

	int send_idle  = 6;
	int recv_idle  = 63;
	int hold_req   = 0;
	int hold_left  = 0;
	int stall_cnt  = 0;
	int n_items    = 0;
	int n_renders  = 0;
	int n_loads    = 0;
	int n_settings = 0;

	// stimulus-side view of the voice, used to load every entry before it is played
	logic [PHASE_W-1:0]     gen_phase = '0;
	logic [PHASE_W-1:0]     gen_step  = '0;
	logic [FRAME_SEL_W-1:0] gen_frame = '0;
	bit                     written [STORE_SIZE];

	always #2 clk = ~clk;

	// receiver: random back-pressure, plus a long hold-off when requested
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			results_ch.ready <= 1'b0;
		end else begin
			results_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (items_ch.valid && items_ch.ready) begin
			sb.note_item(items_ch.opcode, items_ch.load_address, items_ch.load_value);
			if (items_ch.opcode == OP_LOAD)
				n_loads++;
			else
				n_renders++;
		end
		if (results_ch.valid && results_ch.ready)
			sb.check_result(results_ch.left_sample, results_ch.right_sample);
		if (cfg_ch.valid && cfg_ch.ready)
			sb.write_reg(cfg_ch.index, cfg_ch.data);
	end

	always @(posedge clk) begin
		if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("%0t: timeout, no beat on any channel for %0d cycles", $time, STALL_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] wave_value();
		case ($urandom_range(7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [PHASE_W-1:0] pick_step();
		case ($urandom_range(3))
			0: return 32'hFFFF_FFFF;
			1: return $urandom_range(1 << 22);
			2: return $urandom;
			default: return '0;
		endcase
	endfunction

	function automatic wtoh_gain_t random_gains();
		wtoh_gain_t g;
		g.level     = ($urandom_range(3) == 0) ? 17'h10000 : GAIN_W'($urandom_range(65536));
		g.velocity  = ($urandom_range(3) == 0) ? 17'h10000 : GAIN_W'($urandom_range(65536));
		g.pan_left  = ($urandom_range(3) == 0) ? 16'd0 : PAN_W'($urandom_range(32768));
		g.pan_right = ($urandom_range(3) == 0) ? 16'h8000 : PAN_W'($urandom_range(32768));
		return g;
	endfunction

	task automatic send_item(logic op, logic [LOAD_ADDR_W-1:0] addr,
			logic signed [SAMPLE_W-1:0] value);
		while ($urandom_range(99) < send_idle) begin
			items_ch.valid <= 1'b0;
			@(posedge clk);
		end
		items_ch.valid        <= 1'b1;
		items_ch.opcode       <= op;
		items_ch.load_address <= addr;
		items_ch.load_value   <= value;
		do
			@(posedge clk);
		while (!items_ch.ready);
		n_items++;
		if (op == OP_LOAD && addr < STORE_SIZE)
			written[addr] = 1'b1;
	endtask

	// a render beat, preceded by loads of any of its four taps not yet written
	task automatic send_render();
		logic [63:0] pos;
		int          idx, fr, a;
		pos = {32'b0, gen_phase} * 64'(TABLE_DEPTH);
		idx = int'(pos >> 32) % TABLE_DEPTH;
		fr  = int'(gen_frame);
		if (fr > FRAMES - 1)
			fr = FRAMES - 1;
		for (int k = 0; k < 4; k++) begin
			a = fr * TABLE_DEPTH + (idx + k + TABLE_DEPTH - 1) % TABLE_DEPTH;
			if (!written[a])
				send_item(OP_LOAD, LOAD_ADDR_W'(a), wave_value());
		end
		send_item(OP_RENDER, LOAD_ADDR_W'($urandom), SAMPLE_W'($urandom));
		gen_phase = gen_phase + gen_step;
	endtask

	task automatic cfg_beat(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
	endtask

	task automatic apply_setting(logic [PHASE_W-1:0] step, logic [FRAME_SEL_W-1:0] frame,
			wtoh_gain_t g);
		cfg_beat(REG_PHASE_STEP, CFG_DATA_W'(step));
		cfg_beat(REG_FRAME_SELECT, CFG_DATA_W'(frame));
		cfg_beat(REG_LEVEL, CFG_DATA_W'(g.level));
		cfg_beat(REG_VELOCITY, CFG_DATA_W'(g.velocity));
		cfg_beat(REG_PAN_LEFT, CFG_DATA_W'(g.pan_left));
		cfg_beat(REG_PAN_RIGHT, CFG_DATA_W'(g.pan_right));
		cfg_ch.valid <= 1'b0;
		gen_step  = step;
		gen_frame = frame;
		n_settings++;
	endtask

	// stop offering, let every result out, then cover loads still in flight
	task automatic drain_results();
		items_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		sb = new();
		arst_n                = 1'b0;
		items_ch.valid        = 1'b0;
		items_ch.opcode       = OP_RENDER;
		items_ch.load_address = '0;
		items_ch.load_value   = '0;
		results_ch.ready      = 1'b0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.index          = REG_PHASE_STEP;
		cfg_ch.data           = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults straight after reset
		send_render();
		send_render();
		drain_results();

		// alternating full-scale taps across the frame seam: overshoot and saturation
		apply_setting(32'hFFFF_FFFF, 2'd3,
			'{level: 17'h10000, velocity: 17'h10000, pan_left: 16'h8000, pan_right: 16'h8000});
		for (int k = 0; k < 5; k++)
			send_item(OP_LOAD, LOAD_ADDR_W'(3 * TABLE_DEPTH + (k + TABLE_DEPTH - 2) % TABLE_DEPTH),
				(k % 2) ? 16'sh8000 : 16'sh7FFF);
		repeat (3) send_render();
		drain_results();

		// half-cycle steps, silent left channel
		apply_setting(32'h8000_0000, 2'd2,
			'{level: 17'hFFFF, velocity: 17'h8000, pan_left: 16'd0, pan_right: 16'h8000});
		repeat (3) send_render();
		drain_results();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			int start;
			bit paused;
			paused = 1'b0;
			case (p / 4)
				0: begin
					send_idle = 6;
					recv_idle = 63;
				end
				1: begin
					send_idle = 63;
					recv_idle = 6;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			apply_setting(pick_step(), FRAME_SEL_W'($urandom_range(3)), random_gains());
			if (p == 1)
				hold_req = HOLD_CYCLES;
			start = n_items;
			while (n_items - start < PHASE_ITEMS) begin
				if (p == 5 && !paused && n_items - start >= PHASE_ITEMS / 2) begin
					drain_results();
					paused = 1'b1;
				end
				if ($urandom_range(99) < 40)
					send_item(OP_LOAD, LOAD_ADDR_W'($urandom), wave_value());
				else
					send_render();
			end
			drain_results();
		end

		$display("Covered %0d item beats (%0d renders, %0d table loads) over %0d register settings,",
			n_renders + n_loads, n_renders, n_loads, n_settings);
		$display("with sender and receiver stalls, a long result hold-off and a mid-run pause.");
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
